>>> rtl/first_fit_coalescing_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Concurrent check wrappers used by the allocator engine.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_COALESCING_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_COALESCING_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FFCA_CHECK(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("allocator check failed");
`define FFCA_IMPLY(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("allocator implication failed");
`define FFCA_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("allocator next-cycle check failed");
`else
`define FFCA_CHECK(lbl, ck, rn, cond)
`define FFCA_IMPLY(lbl, ck, rn, ante, cons)
`define FFCA_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> rtl/ffca_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Widths, codes and shared types of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

  localparam int MAX_SEG   = 64;
  localparam int ADDR_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_SEG);
  localparam int SCAN_W    = IDX_W + 1;
  localparam int LEN_W     = ADDR_BITS + 1;
  localparam int NEED_W    = LEN_W + 1;
  localparam int CNT_W     = $clog2(MAX_SEG + 1);
  localparam int GB_W      = 8;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [LEN_W-1:0] POOL_MAX      = LEN_W'(1) << ADDR_BITS;
  localparam logic [GB_W-1:0]  DEFAULT_GUARD = GB_W'(16);

  typedef enum logic [1:0] {
    REG_POOL        = 2'd0,
    REG_GUARD_ON    = 2'd1,
    REG_GUARD_BYTES = 2'd2
  } reg_idx_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_WR1,
    ST_WR2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [LEN_W-1:0]     len;
    logic [LEN_W-1:0]     payload;
  } seg_t;

  typedef struct packed {
    logic [LEN_W-1:0] pool;
    logic             guard_on;
    logic [GB_W-1:0]  guard_bytes;
  } cfg_t;

  typedef struct packed {
    logic                 func;
    logic [LEN_W-1:0]     req_size;
    logic [ADDR_BITS-1:0] user_offset;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [ADDR_BITS-1:0] alloc_offset;
    logic [LEN_W-1:0]     bytes_left;
    logic [CNT_W-1:0]     free_count;
    logic [CNT_W-1:0]     used_count;
  } res_t;

  function automatic logic [GB_W-1:0] guard_len(input cfg_t c);
    logic [GB_W-1:0] g;
    g = '0;
    if (c.guard_on) begin
      g = (c.guard_bytes == '0) ? DEFAULT_GUARD : c.guard_bytes;
    end
    return g;
  endfunction

endpackage

>>> rtl/ffca_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ffca_engine.sv
// ----------------------------------------------------------------------------
// Allocator engine
// Scans the segment table in RAM, selects segments and writes back splits
// and merges; keeps valid/used flags, counters and remaining bytes.
// ----------------------------------------------------------------------------
`include "first_fit_coalescing_allocator_top_macros.svh"

module ffca_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ffca_pkg::cfg_t             cfg,
  input  logic                       init_req,
  input  logic [ffca_pkg::LEN_W-1:0] init_pool,
  input  logic                       req_valid,
  input  ffca_pkg::req_t             req,
  output logic                       idle,
  output logic                       res_valid,
  input  logic                       res_take,
  output ffca_pkg::res_t             res,
  output logic [ffca_pkg::CNT_W-1:0] used_count
);

  ffca_pkg::state_t state_r, state_nxt;

  logic [ffca_pkg::MAX_SEG-1:0]   valid_r, use_r;
  logic                           init_r;
  logic [ffca_pkg::LEN_W-1:0]     remaining_r;
  logic [ffca_pkg::CNT_W-1:0]     free_cnt_r, used_cnt_r;

  logic                           func_r;
  logic [ffca_pkg::LEN_W-1:0]     size_r;
  logic [ffca_pkg::ADDR_BITS-1:0] uoff_r;
  logic [ffca_pkg::GB_W-1:0]      g_r;
  logic [ffca_pkg::NEED_W-1:0]    need_r;
  logic                           pass_r;
  logic [ffca_pkg::SCAN_W-1:0]    scan_r;
  logic                           rv_r;
  logic [ffca_pkg::IDX_W-1:0]     ridx_r;

  logic                           best_f_r, slot_f_r, cur_f_r, prev_f_r, next_f_r;
  logic [ffca_pkg::IDX_W-1:0]     best_idx_r, slot_idx_r, cur_idx_r, prev_idx_r, next_idx_r;
  logic [ffca_pkg::ADDR_BITS-1:0] best_start_r, cur_start_r, prev_start_r, next_start_r;
  logic [ffca_pkg::LEN_W-1:0]     best_len_r, cur_len_r, prev_len_r, next_len_r, cur_pay_r;

  logic [ffca_pkg::IDX_W-1:0]     wa_r, wb_r;
  ffca_pkg::seg_t                 wad_r, wbd_r;
  logic                           ok_r;
  logic [ffca_pkg::ADDR_BITS-1:0] off_r;

  logic                           ram_we;
  logic [ffca_pkg::IDX_W-1:0]     ram_waddr;
  ffca_pkg::seg_t                 ram_wdata, ram_rdata, ent;
  logic                           issue, e_valid, e_use;
  logic [ffca_pkg::GB_W-1:0]      g_in;
  logic [ffca_pkg::NEED_W-1:0]    need_in;
  logic                           early_fail;
  logic                           split, a_fail, mp, mn;
  logic [ffca_pkg::ADDR_BITS-1:0] base_start;
  logic [ffca_pkg::LEN_W-1:0]     base_len, final_len;
  logic [ffca_pkg::IDX_W-1:0]     base_idx;

  ffca_ram #(
    .WIDTH ($bits(ffca_pkg::seg_t)),
    .DEPTH (ffca_pkg::MAX_SEG)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r[ffca_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    g_in       = ffca_pkg::guard_len(cfg);
    need_in    = ffca_pkg::NEED_W'(req.req_size) + ffca_pkg::NEED_W'({g_in, 1'b0});
    early_fail = (req.func == ffca_pkg::FUNC_ALLOC) &&
                 (need_in > ffca_pkg::NEED_W'(remaining_r));
    issue      = (state_r == ffca_pkg::ST_SCAN) &&
                 (scan_r < ffca_pkg::SCAN_W'(ffca_pkg::MAX_SEG));
    ent        = ram_rdata;
    if (init_r && (ridx_r == '0)) begin
      ent = '{start: '0, len: cfg.pool, payload: '0};
    end
    e_valid    = valid_r[ridx_r];
    e_use      = use_r[ridx_r];
    ram_we     = (state_r == ffca_pkg::ST_WR1) || (state_r == ffca_pkg::ST_WR2);
    ram_waddr  = (state_r == ffca_pkg::ST_WR1) ? wa_r : wb_r;
    ram_wdata  = (state_r == ffca_pkg::ST_WR1) ? wad_r : wbd_r;

    split      = ffca_pkg::NEED_W'(best_len_r) > need_r;
    a_fail     = !best_f_r || (split && !slot_f_r);
    mp         = prev_f_r &&
                 ((ffca_pkg::LEN_W'(prev_start_r) + prev_len_r) ==
                  ffca_pkg::LEN_W'(cur_start_r));
    base_start = mp ? prev_start_r : cur_start_r;
    base_len   = mp ? (prev_len_r + cur_len_r) : cur_len_r;
    base_idx   = mp ? prev_idx_r : cur_idx_r;
    mn         = next_f_r &&
                 ((ffca_pkg::LEN_W'(base_start) + base_len) ==
                  ffca_pkg::LEN_W'(next_start_r));
    final_len  = base_len + (mn ? next_len_r : '0);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffca_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_nxt = early_fail ? ffca_pkg::ST_DONE : ffca_pkg::ST_SCAN;
        end
      end
      ffca_pkg::ST_SCAN: begin
        if (!issue && !rv_r) begin
          state_nxt = ffca_pkg::ST_EVAL;
        end
      end
      ffca_pkg::ST_EVAL: begin
        if (func_r == ffca_pkg::FUNC_ALLOC) begin
          if (a_fail) begin
            state_nxt = ffca_pkg::ST_DONE;
          end else begin
            state_nxt = split ? ffca_pkg::ST_WR1 : ffca_pkg::ST_WR2;
          end
        end else if (!pass_r) begin
          state_nxt = cur_f_r ? ffca_pkg::ST_SCAN : ffca_pkg::ST_DONE;
        end else begin
          state_nxt = ffca_pkg::ST_WR2;
        end
      end
      ffca_pkg::ST_WR1: state_nxt = ffca_pkg::ST_WR2;
      ffca_pkg::ST_WR2: state_nxt = ffca_pkg::ST_DONE;
      ffca_pkg::ST_DONE: begin
        if (res_take) begin
          state_nxt = ffca_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffca_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // table flags and counters
  always_ff @(posedge clk) begin
    if (!rst_n || init_req) begin
      valid_r     <= ffca_pkg::MAX_SEG'(1);
      use_r       <= '0;
      init_r      <= 1'b1;
      remaining_r <= rst_n ? init_pool : ffca_pkg::POOL_MAX;
      free_cnt_r  <= ffca_pkg::CNT_W'(1);
      used_cnt_r  <= '0;
    end else begin
      if (ram_we && (ram_waddr == '0)) begin
        init_r <= 1'b0;
      end
      if (state_r == ffca_pkg::ST_EVAL) begin
        if (func_r == ffca_pkg::FUNC_ALLOC) begin
          if (!a_fail) begin
            use_r[best_idx_r] <= 1'b1;
            remaining_r       <= remaining_r - size_r;
            used_cnt_r        <= used_cnt_r + 1'b1;
            if (split) begin
              valid_r[slot_idx_r] <= 1'b1;
              use_r[slot_idx_r]   <= 1'b0;
            end else begin
              free_cnt_r <= free_cnt_r - 1'b1;
            end
          end
        end else if (pass_r) begin
          use_r[cur_idx_r] <= 1'b0;
          remaining_r      <= remaining_r + cur_pay_r;
          used_cnt_r       <= used_cnt_r - 1'b1;
          free_cnt_r       <= free_cnt_r + 1'b1 - ffca_pkg::CNT_W'(mp) -
                              ffca_pkg::CNT_W'(mn);
          if (mp) begin
            valid_r[cur_idx_r] <= 1'b0;
          end
          if (mn) begin
            valid_r[next_idx_r] <= 1'b0;
          end
        end
      end
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ffca_pkg::ST_IDLE: begin
        func_r   <= req.func;
        size_r   <= req.req_size;
        uoff_r   <= req.user_offset;
        g_r      <= g_in;
        need_r   <= need_in;
        pass_r   <= 1'b0;
        scan_r   <= '0;
        rv_r     <= 1'b0;
        best_f_r <= 1'b0;
        slot_f_r <= 1'b0;
        cur_f_r  <= 1'b0;
        prev_f_r <= 1'b0;
        next_f_r <= 1'b0;
        ok_r     <= 1'b0;
        off_r    <= '0;
      end
      ffca_pkg::ST_SCAN: begin
        rv_r   <= issue;
        ridx_r <= scan_r[ffca_pkg::IDX_W-1:0];
        if (issue) begin
          scan_r <= scan_r + 1'b1;
        end
        if (rv_r) begin
          if (func_r == ffca_pkg::FUNC_ALLOC) begin
            if (!e_valid && !slot_f_r) begin
              slot_f_r   <= 1'b1;
              slot_idx_r <= ridx_r;
            end
            if (e_valid && !e_use && (ffca_pkg::NEED_W'(ent.len) >= need_r) &&
                (!best_f_r || (ent.start < best_start_r))) begin
              best_f_r     <= 1'b1;
              best_idx_r   <= ridx_r;
              best_start_r <= ent.start;
              best_len_r   <= ent.len;
            end
          end else if (!pass_r) begin
            if (e_valid && e_use &&
                ((ffca_pkg::LEN_W'(ent.start) + ffca_pkg::LEN_W'(g_r)) ==
                 ffca_pkg::LEN_W'(uoff_r)) &&
                (!cur_f_r || (ent.start < cur_start_r))) begin
              cur_f_r     <= 1'b1;
              cur_idx_r   <= ridx_r;
              cur_start_r <= ent.start;
              cur_len_r   <= ent.len;
              cur_pay_r   <= ent.payload;
            end
          end else if (e_valid && !e_use && (ridx_r != cur_idx_r)) begin
            if ((ent.start < cur_start_r) && (!prev_f_r || (ent.start > prev_start_r))) begin
              prev_f_r     <= 1'b1;
              prev_idx_r   <= ridx_r;
              prev_start_r <= ent.start;
              prev_len_r   <= ent.len;
            end
            if ((ent.start >= cur_start_r) && (!next_f_r || (ent.start < next_start_r))) begin
              next_f_r     <= 1'b1;
              next_idx_r   <= ridx_r;
              next_start_r <= ent.start;
              next_len_r   <= ent.len;
            end
          end
        end
      end
      ffca_pkg::ST_EVAL: begin
        if (func_r == ffca_pkg::FUNC_ALLOC) begin
          ok_r  <= !a_fail;
          off_r <= a_fail ? '0 :
                   (best_start_r + ffca_pkg::ADDR_BITS'(g_r));
          wa_r  <= slot_idx_r;
          wad_r <= '{start:   ffca_pkg::ADDR_BITS'(ffca_pkg::NEED_W'(best_start_r) + need_r),
                     len:     ffca_pkg::LEN_W'(ffca_pkg::NEED_W'(best_len_r) - need_r),
                     payload: '0};
          wb_r  <= best_idx_r;
          wbd_r <= '{start: best_start_r, len: ffca_pkg::LEN_W'(need_r), payload: size_r};
        end else if (!pass_r) begin
          pass_r <= 1'b1;
          scan_r <= '0;
          rv_r   <= 1'b0;
        end else begin
          ok_r  <= 1'b1;
          wb_r  <= base_idx;
          wbd_r <= '{start: base_start, len: final_len, payload: '0};
        end
      end
      default: begin
        rv_r <= 1'b0;
      end
    endcase
  end

  assign idle       = (state_r == ffca_pkg::ST_IDLE);
  assign res_valid  = (state_r == ffca_pkg::ST_DONE);
  assign used_count = used_cnt_r;
  assign res        = '{ok: ok_r, alloc_offset: off_r, bytes_left: remaining_r,
                        free_count: free_cnt_r, used_count: used_cnt_r};

  `FFCA_CHECK(a_seg_counts, clk, rst_n, (ffca_pkg::CNT_W+1)'(free_cnt_r) + (ffca_pkg::CNT_W+1)'(used_cnt_r) == (ffca_pkg::CNT_W+1)'($countones(valid_r)))
  `FFCA_CHECK(a_used_is_valid, clk, rst_n, (use_r & ~valid_r) == '0)
  `FFCA_IMPLY(a_write_phase, clk, rst_n, ram_we, (func_r == ffca_pkg::FUNC_FREE) || ok_r || (state_r == ffca_pkg::ST_WR1))
  `FFCA_NEXT(a_init_table, clk, rst_n, init_req, (valid_r == ffca_pkg::MAX_SEG'(1)) && (use_r == '0))

endmodule

>>> rtl/first_fit_coalescing_allocator_top.sv
// ----------------------------------------------------------------------------
// First-fit coalescing allocator, top level
// Configuration registers, output register and the allocator engine.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_stall    func, req_size, user_offset
//   out_     output     out_valid/out_stall  ok, alloc_offset, bytes_left,
//                                            free_count, used_count
//   cfg_     APB write  psel/penable/pwrite  pool_bytes, guard_on, guard_bytes
//
// An allocate makes one pass over the 64-entry segment RAM (one read per
// cycle) and, on success, one or two write-backs. A free makes one pass to
// find the segment and, if found, one for its neighbours and a write-back.
// An allocate whose size plus both guards exceeds the remaining bytes skips
// the scan. in_stall is high while a request is in progress, which lasts until
// its result enters the output register. No clearing pass after reset.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_func,
  input  logic [ffca_pkg::LEN_W-1:0]     in_req_size,
  input  logic [ffca_pkg::ADDR_BITS-1:0] in_user_offset,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_ok,
  output logic [ffca_pkg::ADDR_BITS-1:0] out_alloc_offset,
  output logic [ffca_pkg::LEN_W-1:0]     out_bytes_left,
  output logic [ffca_pkg::CNT_W-1:0]     out_free_count,
  output logic [ffca_pkg::CNT_W-1:0]     out_used_count,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [ffca_pkg::PADDR_W-1:0]   cfg_paddr,
  input  logic [ffca_pkg::PDATA_W-1:0]   cfg_pwdata,
  output logic [ffca_pkg::PDATA_W-1:0]   cfg_prdata,
  output logic                           cfg_pready
);

  ffca_pkg::cfg_t             cfg_r;
  ffca_pkg::req_t             req;
  ffca_pkg::res_t             res, out_r;
  ffca_pkg::reg_idx_t         reg_idx;
  logic                       out_valid_r;
  logic                       wr_en, init_req, idle, res_valid, res_take;
  logic [ffca_pkg::CNT_W-1:0] used_count;
  logic [ffca_pkg::LEN_W-1:0] pool_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = ffca_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign init_req   = wr_en && (reg_idx == ffca_pkg::REG_POOL);

  always_comb begin
    pool_wr = cfg_pwdata[ffca_pkg::LEN_W-1:0];
    if (pool_wr == '0) begin
      pool_wr = ffca_pkg::LEN_W'(1);
    end else if (pool_wr > ffca_pkg::POOL_MAX) begin
      pool_wr = ffca_pkg::POOL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pool: ffca_pkg::POOL_MAX, guard_on: 1'b0,
                 guard_bytes: ffca_pkg::DEFAULT_GUARD};
    end else if (wr_en) begin
      case (reg_idx)
        ffca_pkg::REG_POOL:        cfg_r.pool <= pool_wr;
        ffca_pkg::REG_GUARD_ON: begin
          if (cfg_pwdata[0] || (used_count == '0)) begin
            cfg_r.guard_on <= cfg_pwdata[0];
          end
        end
        ffca_pkg::REG_GUARD_BYTES: cfg_r.guard_bytes <= cfg_pwdata[ffca_pkg::GB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ffca_pkg::REG_POOL:        cfg_prdata = ffca_pkg::PDATA_W'(cfg_r.pool);
      ffca_pkg::REG_GUARD_ON:    cfg_prdata = ffca_pkg::PDATA_W'(cfg_r.guard_on);
      ffca_pkg::REG_GUARD_BYTES: cfg_prdata = ffca_pkg::PDATA_W'(cfg_r.guard_bytes);
      default:                   cfg_prdata = '0;
    endcase
  end

  assign req = '{func: in_func, req_size: in_req_size, user_offset: in_user_offset};

  ffca_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .init_req   (init_req),
    .init_pool  (pool_wr),
    .req_valid  (in_valid),
    .req        (req),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .used_count (used_count)
  );

  assign in_stall = !idle;
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_r.ok;
  assign out_alloc_offset = out_r.alloc_offset;
  assign out_bytes_left   = out_r.bytes_left;
  assign out_free_count   = out_r.free_count;
  assign out_used_count   = out_r.used_count;

endmodule
